// File: design/stree_pkg.sv
// Shared constants and types for the segment tree range sum core.
`timescale 1ns / 1ps

package stree_pkg;

    localparam int CFG_W       = 11;
    localparam int POS_W       = 10;
    localparam int DATA_W      = 32;
    localparam int LEAVES_DEF  = 1024;

    localparam logic [CFG_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [0:0] {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

endpackage

// File: design/stree_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module stree_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/segment_tree_range_sum_core.sv
// Top level: segment tree of partial sums with point update and range sum query.
//
//  channel | valid / ready            | payload
//  --------+--------------------------+------------------------------------------------
//  in      | i_in_valid / o_in_ready  | i_command i_position i_value i_range_low/high
//  out     | o_out_valid / i_out_ready| o_range_sum o_rejected
//  cfg     | i_cfg_valid / o_cfg_ready| i_cfg_data (element_count)
//
//  One item at a time. Update: one sibling read and one ancestor write per tree level on
//  the node RAM. Query: one level per cycle, two reads per level from the replicated node
//  RAM. Rejected updates and empty queries go from idle straight to the done state.
//  After reset a clearing pass zeroes all 2*LEAVES words of the node RAM; no item is taken
//  meanwhile, configuration writes are. A stalled output holds the next result back.
`timescale 1ns / 1ps

module segment_tree_range_sum_core
    import stree_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_command,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_range_low,
    input  logic [POS_W-1:0]         i_range_high,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_range_sum,
    output logic                     o_rejected,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int DEPTH = 2 * LEAVES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int XW    = (NW > CFG_W) ? NW : CFG_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ULEAF,
        S_UWALK,
        S_QWALK,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [NW-1:0]       r_k;
    logic [NW-1:0]       r_a;
    logic [NW-1:0]       r_b;
    logic                r_p0;
    logic                r_p1;
    logic [DATA_W-1:0]   r_acc;
    logic                r_rej;
    logic [CFG_W-1:0]    r_count;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_range_sum;
    logic                r_rejected;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [DATA_W-1:0]   wdata;
    logic [AW-1:0]       raddr0;
    logic [AW-1:0]       raddr1;
    logic [DATA_W-1:0]   rd0;
    logic [DATA_W-1:0]   rd1;

    logic [XW-1:0]       cnt_x;
    logic [XW-1:0]       lv_x;
    logic [XW-1:0]       cnt_eff;
    logic [XW-1:0]       pos_x;
    logic [XW-1:0]       lo_x;
    logic [XW-1:0]       hi_x;
    logic [XW-1:0]       hi_c;
    logic                upd_ok;
    logic                q_empty;
    logic [NW-1:0]       a_init;
    logic [NW-1:0]       b_init;
    logic [NW-1:0]       k_init;

    logic [NW-1:0]       kp;
    logic [DATA_W-1:0]   upd_sum;
    logic                q_act;
    logic [NW-1:0]       n_a;
    logic [NW-1:0]       n_b;
    logic [NW-1:0]       b_dec;
    logic [DATA_W-1:0]   n_sum;
    logic                in_fire;
    logic                out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // item decode
    always_comb begin
        cnt_x   = XW'(r_count);
        lv_x    = XW'(LEAVES);
        cnt_eff = (cnt_x > lv_x) ? lv_x : cnt_x;
        pos_x   = XW'(i_position);
        lo_x    = XW'(i_range_low);
        hi_x    = XW'(i_range_high);
        hi_c    = (hi_x >= cnt_eff) ? (cnt_eff - XW'(1)) : hi_x;
        upd_ok  = (pos_x < cnt_eff);
        q_empty = (cnt_eff == '0) || (lo_x > hi_c);
        k_init  = NW'(lv_x + pos_x);
        a_init  = NW'(lv_x + lo_x);
        b_init  = NW'(lv_x + hi_c + XW'(1));
    end

    // tree walk arithmetic
    always_comb begin
        kp      = r_k >> 1;
        upd_sum = r_acc + rd0;
        q_act   = (r_a < r_b);
        n_a     = NW'(r_a + NW'(r_a[0])) >> 1;
        n_b     = NW'(r_b - NW'(r_b[0])) >> 1;
        b_dec   = r_b - NW'(1);
        n_sum   = r_acc + (r_p0 ? rd0 : '0) + (r_p1 ? rd1 : '0);
    end

    // RAM ports
    always_comb begin
        we     = 1'b0;
        waddr  = r_k[AW-1:0];
        wdata  = r_acc;
        raddr0 = '0;
        raddr1 = '0;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wdata = '0;
            end
            S_ULEAF: begin
                we     = 1'b1;
                raddr0 = r_k[AW-1:0] ^ AW'(1);
            end
            S_UWALK: begin
                we     = 1'b1;
                waddr  = kp[AW-1:0];
                wdata  = upd_sum;
                raddr0 = kp[AW-1:0] ^ AW'(1);
            end
            S_QWALK: begin
                raddr0 = r_a[AW-1:0];
                raddr1 = b_dec[AW-1:0];
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    stree_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr0),
        .o_rdata (rd0)
    );

    stree_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr1),
        .o_rdata (rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_count     <= COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_k <= r_k + NW'(1);
                    if (r_k == NW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_p0  <= 1'b0;
                        r_p1  <= 1'b0;
                        r_a   <= a_init;
                        r_b   <= b_init;
                        if (t_cmd'(i_command) == CMD_UPDATE) begin
                            r_rej <= !upd_ok;
                            if (upd_ok) begin
                                r_k     <= k_init;
                                r_acc   <= i_value;
                                r_state <= S_ULEAF;
                            end else begin
                                r_acc   <= '0;
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_rej   <= 1'b0;
                            r_acc   <= '0;
                            r_state <= q_empty ? S_DONE : S_QWALK;
                        end
                    end
                end
                S_ULEAF: begin
                    r_state <= S_UWALK;
                end
                S_UWALK: begin
                    r_k <= kp;
                    if (kp == NW'(1)) begin
                        r_acc   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_acc <= upd_sum;
                    end
                end
                S_QWALK: begin
                    r_acc <= n_sum;
                    if (q_act) begin
                        r_p0 <= r_a[0];
                        r_p1 <= r_b[0];
                        r_a  <= n_a;
                        r_b  <= n_b;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_range_sum <= r_acc;
                        r_rejected  <= r_rej;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_range_sum;
    assign o_rejected  = r_rejected;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> (o_range_sum == '0))
        else $error("rejected update carries a non-zero sum");

    a_walk_above_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UWALK) |-> (r_k > NW'(1)))
        else $error("update walk passed the root");

    a_query_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QWALK) |-> (r_b <= NW'(DEPTH)))
        else $error("query bound beyond the tree");

endmodule

// File: verif/segment_tree_range_sum_core_test.sv
// Testbench for the segment tree core: directed table, then randomised update and query bursts.
`timescale 1ns / 1ps

module segment_tree_range_sum_core_test
    import stree_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int ROWS          = 28;

    typedef enum logic [0:0] {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } t_pace;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              rej;
    } t_outcome;

    typedef struct packed {
        t_row_kind         kind;
        t_cmd              cmd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic              typed;
        logic [DATA_W-1:0] sum;
        logic              rej;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_ready;
    logic                     i_command    = 1'b0;
    logic [POS_W-1:0]         i_position   = '0;
    logic signed [DATA_W-1:0] i_value      = '0;
    logic [POS_W-1:0]         i_range_low  = '0;
    logic [POS_W-1:0]         i_range_high = '0;
    logic                     o_out_valid;
    logic                     i_out_ready  = 1'b0;
    logic signed [DATA_W-1:0] o_range_sum;
    logic                     o_rejected;
    logic                     i_cfg_valid  = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_W-1:0]         i_cfg_data   = '0;

    logic [DATA_W-1:0] element_vals [LEAVES_DEF];
    logic [CFG_W-1:0]  elem_count = COUNT_RESET;
    t_outcome          awaited_sums [$];
    t_row              directed_rows [ROWS];
    int                mismatch_count = 0;
    int                cycle_count    = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_orders    = 0;
    int                hold_taken     = 0;
    int                stall_left     = 0;

    segment_tree_range_sum_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_range_sum  (o_range_sum),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_outcome sum_after_command(input t_cmd c, input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val,
                                                   input logic [POS_W-1:0] lo,
                                                   input logic [POS_W-1:0] hi);
        t_outcome res;
        int       live;
        int       top;
        res  = '0;
        live = (elem_count > LEAVES_DEF) ? LEAVES_DEF : int'(elem_count);
        if (c == CMD_UPDATE) begin
            if (int'(pos) < live) begin
                element_vals[pos] = val;
            end else begin
                res.rej = 1'b1;
            end
        end else if (live > 0) begin
            top = (int'(hi) > live - 1) ? live - 1 : int'(hi);
            for (int i = int'(lo); i <= top; i++) begin
                res.sum = res.sum + element_vals[i];
            end
        end
        return res;
    endfunction

    // check results, then drive ready for the next edge
    always @(posedge i_clk) begin : result_side
        t_outcome want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (awaited_sums.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: sum %h rejected %b", o_range_sum, o_rejected);
                end
            end else begin
                want = awaited_sums.pop_front();
                if (o_range_sum !== want.sum || o_rejected !== want.rej) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: sum %h rejected %b, expected sum %h rejected %b",
                                 o_range_sum, o_rejected, want.sum, want.rej);
                    end
                end
            end
        end
        if (hold_taken != hold_orders) begin
            hold_taken = hold_orders;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic issue(input t_cmd c, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val, input logic [POS_W-1:0] lo,
                         input logic [POS_W-1:0] hi, input logic typed,
                         input logic [DATA_W-1:0] sum, input logic rej);
        int       gap;
        t_outcome res;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= c;
        i_position   <= pos;
        i_value      <= val;
        i_range_low  <= lo;
        i_range_high <= hi;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        res = sum_after_command(c, pos, val, lo, hi);
        if (typed) begin
            res.sum = sum;
            res.rej = rej;
        end
        awaited_sums.push_back(res);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] n);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        elem_count = n;
    endtask

    task automatic run_burst(input logic [CFG_W-1:0] n, input int items, input t_pace pace,
                             input bit squeeze);
        int                live;
        int                pick;
        int                a;
        int                b;
        logic [DATA_W-1:0] val;
        write_count(n);
        live           = (n > LEAVES_DEF) ? LEAVES_DEF : int'(n);
        send_idle_pct  = (pace == PACE_SENDER_IDLE) ? 76 : (pace == PACE_BOTH) ? 24 : 0;
        recv_stall_pct = (pace == PACE_RECEIVER_STALL) ? 76 : (pace == PACE_BOTH) ? 24 : 0;
        for (int k = 0; k < items; k++) begin
            if (squeeze && k == items / 2) begin
                hold_orders++;
            end
            case ($urandom_range(0, 9))
                0: val = 32'h7FFF_FFFF;
                1: val = 32'h8000_0000;
                2: val = $urandom_range(0, 20) - 10;
                default: val = $urandom();
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 45 && live > 0) begin
                issue(CMD_UPDATE, POS_W'($urandom_range(0, live - 1)), val,
                      POS_W'($urandom()), POS_W'($urandom()), 1'b0, '0, 1'b0);
            end else if (pick < 55) begin
                issue(CMD_UPDATE, POS_W'($urandom()), val, POS_W'($urandom()),
                      POS_W'($urandom()), 1'b0, '0, 1'b0);
            end else if (pick < 90 && live > 0) begin
                a = $urandom_range(0, live - 1);
                b = $urandom_range(0, live - 1);
                issue(CMD_QUERY, POS_W'($urandom()), $urandom(), POS_W'((a < b) ? a : b),
                      POS_W'((a < b) ? b : a), 1'b0, '0, 1'b0);
            end else begin
                issue(CMD_QUERY, POS_W'($urandom()), $urandom(), POS_W'($urandom()),
                      POS_W'($urandom()), 1'b0, '0, 1'b0);
            end
        end
    endtask

    initial begin
        foreach (element_vals[i]) element_vals[i] = '0;
        directed_rows = '{
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_UPDATE, 10'd0, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_UPDATE, 10'd1023, 32'h8000_0000, 10'd0, 10'd0, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023, 1'b1, 32'hFFFF_FFFF, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd0, 10'd0, 1'b1, 32'h7FFF_FFFF, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd1023, 10'd1023, 1'b1, 32'h8000_0000, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd5, 10'd3, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_UPDATE, 10'd1, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd0, 10'd1, 1'b1, 32'hFFFF_FFFE, 1'b0},
            '{ROW_ITEM, CMD_UPDATE, 10'd512, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_UPDATE, 10'd341, 32'h5555_5555, 10'd0, 10'd0, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd1, 10'd1022, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd682, 10'd1023, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG, CMD_UPDATE, 10'd0, 32'd10, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_UPDATE, 10'd10, 32'd5, 10'd0, 10'd0, 1'b1, 32'h0, 1'b1},
            '{ROW_ITEM, CMD_UPDATE, 10'd1023, 32'd1, 10'd0, 10'd0, 1'b1, 32'h0, 1'b1},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd9, 10'd1023, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd10, 10'd1023, 1'b1, 32'h0, 1'b0},
            '{ROW_CFG, CMD_UPDATE, 10'd0, 32'd0, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_UPDATE, 10'd0, 32'd3, 10'd0, 10'd0, 1'b1, 32'h0, 1'b1},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd0, 10'd0, 1'b1, 32'h0, 1'b0},
            '{ROW_CFG, CMD_UPDATE, 10'd0, 32'd2047, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_UPDATE, 10'd1023, 32'd7, 10'd0, 10'd0, 1'b1, 32'h0, 1'b0},
            '{ROW_CFG, CMD_UPDATE, 10'd0, 32'd1, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, CMD_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG, CMD_UPDATE, 10'd0, 32'd1024, 10'd0, 10'd0, 1'b0, 32'h0, 1'b0}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_count(directed_rows[r].val[CFG_W-1:0]);
            end else begin
                issue(directed_rows[r].cmd, directed_rows[r].pos, directed_rows[r].val,
                      directed_rows[r].lo, directed_rows[r].hi, directed_rows[r].typed,
                      directed_rows[r].sum, directed_rows[r].rej);
            end
        end

        run_burst(11'd1024, 300, PACE_FREE,           1'b1);
        run_burst(11'd37,   200, PACE_SENDER_IDLE,    1'b0);
        run_burst(11'd1,    60,  PACE_RECEIVER_STALL, 1'b0);
        run_burst(11'd2047, 250, PACE_BOTH,           1'b0);
        run_burst(11'd0,    40,  PACE_FREE,           1'b0);
        run_burst(11'd700,  250, PACE_SENDER_IDLE,    1'b0);
        run_burst(11'd16,   200, PACE_RECEIVER_STALL, 1'b1);
        run_burst(11'd1024, 300, PACE_BOTH,           1'b0);
        run_burst(11'd513,  100, PACE_FREE,           1'b0);
        settle();

        if (mismatch_count == 0 && awaited_sums.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
